// File: src/ryc_pkg.sv
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared constants for the RGB / BT.601 YPbPr converter: weights in
// millionths, register codes, reset values and fixed datapath widths.
// ----------------------------------------------------------------------------
package ryc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // coefficient width, signed, holds every weight in millionths
  localparam int CW = 22;

  // forward magnitude |sum| stays below 2^36 for 16-bit samples
  localparam int SMW = 36;

  // divisor width: 2 * 10^6 * 65535 < 2^38
  localparam int DW = 38;

  localparam int unsigned MILLION = 1000000;

  localparam logic [1:0] CFG_DIRECTION = 2'd0;
  localparam logic [1:0] CFG_MAX_VALUE = 2'd1;

  localparam logic [15:0]   MAX_VALUE_RST = 16'd255;
  localparam logic [DW-1:0] DEN_FWD_RST   = DW'(64'd510000000);

  // [channel][sample]: rows Y, Pb, Pr; columns R, G, B
  localparam logic signed [CW-1:0] FWD_COEF [3][3] = '{
    '{ 22'sd299000,  22'sd587000,  22'sd114000},
    '{-22'sd168736, -22'sd331264,  22'sd500000},
    '{ 22'sd500000, -22'sd418688, -22'sd81312}
  };

  // [channel][operand]: rows R, G, B; columns Y, Pb, Pr
  localparam logic signed [CW-1:0] INV_COEF [3][3] = '{
    '{22'sd1000000,  22'sd0,       22'sd1402000},
    '{22'sd1000000, -22'sd344136, -22'sd714136},
    '{22'sd1000000,  22'sd1772000, 22'sd0}
  };

endpackage

// File: src/ryc_weight.sv
// ----------------------------------------------------------------------------
// ryc_weight
// Three-stage weighting: constant products, channel sums, then sign and
// magnitude (forward) or clamp to [0, full scale] (inverse).
// ----------------------------------------------------------------------------
module ryc_weight
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_dir,
  input  logic [15:0]                   red,
  input  logic [15:0]                   green,
  input  logic [15:0]                   blue,
  input  logic signed [FRAC_BITS+1:0]   luma,
  input  logic signed [FRAC_BITS+1:0]   blue_diff,
  input  logic signed [FRAC_BITS+1:0]   red_diff,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_dir,
  output logic                          out_neg [3],
  output logic [((FRAC_BITS+20 > SMW) ? FRAC_BITS+20 : SMW)-1:0] out_val [3]
);

  localparam int IW = FRAC_BITS + 2;
  localparam int OW = (IW > 17) ? IW : 17;
  localparam int PW = OW + CW;
  localparam int SW = PW + 2;
  localparam int VW = (FRAC_BITS + 20 > SMW) ? FRAC_BITS + 20 : SMW;
  localparam logic [VW-1:0] FULL = VW'(64'd1000000 << FRAC_BITS);

  logic [2:0] vld;
  logic       en0, en1, en2;

  logic signed [OW-1:0] opf [3];
  logic signed [OW-1:0] opi [3];
  logic signed [PW-1:0] prod [3][3];

  logic signed [PW-1:0] p1 [3][3];
  logic                 dir1;
  logic signed [SW-1:0] s2 [3];
  logic                 dir2;
  logic [VW-1:0]        v3 [3];
  logic                 neg3 [3];
  logic                 dir3;

  assign en2      = !vld[2] || out_ready;
  assign en1      = !vld[1] || en2;
  assign en0      = !vld[0] || en1;
  assign in_ready = en0;

  always_comb begin
    opf[0] = $signed(OW'({1'b0, red}));
    opf[1] = $signed(OW'({1'b0, green}));
    opf[2] = $signed(OW'({1'b0, blue}));
    opi[0] = OW'(luma);
    opi[1] = OW'(blue_diff);
    opi[2] = OW'(red_diff);
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 3; k++) begin
        if (in_dir) begin
          prod[c][k] = $signed(PW'(opi[k])) * $signed(PW'(INV_COEF[c][k]));
        end else begin
          prod[c][k] = $signed(PW'(opf[k])) * $signed(PW'(FWD_COEF[c][k]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en0) vld[0] <= in_valid;
      if (en1) vld[1] <= vld[0];
      if (en2) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      p1   <= prod;
      dir1 <= in_dir;
    end
    if (en1) begin
      for (int c = 0; c < 3; c++) begin
        s2[c] <= SW'(p1[c][0]) + SW'(p1[c][1]) + SW'(p1[c][2]);
      end
      dir2 <= dir1;
    end
    if (en2) begin
      for (int c = 0; c < 3; c++) begin
        if (dir2) begin
          // clamp the channel to [0, 1]
          neg3[c] <= 1'b0;
          if (s2[c][SW-1]) begin
            v3[c] <= '0;
          end else if (s2[c] > $signed(SW'(FULL))) begin
            v3[c] <= FULL;
          end else begin
            v3[c] <= VW'(s2[c]);
          end
        end else begin
          neg3[c] <= s2[c][SW-1];
          v3[c]   <= s2[c][SW-1] ? VW'(-s2[c]) : VW'(s2[c]);
        end
      end
      dir3 <= dir2;
    end
  end

  assign out_valid = vld[2];
  assign out_dir   = dir3;
  assign out_neg   = neg3;
  assign out_val   = v3;

endmodule

// File: src/ryc_scale.sv
// ----------------------------------------------------------------------------
// ryc_scale
// Two-stage numerator build. Forward: 2*|S|*2^F + d over 2d. Inverse: the
// clamped channel times max_value in two partial products, plus half scale,
// shifted down by the fraction bits, over 10^6.
// ----------------------------------------------------------------------------
module ryc_scale
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_dir,
  input  logic                   in_neg [3],
  input  logic [((FRAC_BITS+20 > SMW) ? FRAC_BITS+20 : SMW)-1:0] in_val [3],
  input  logic [15:0]            max_value,
  input  logic [DW-1:0]          den_fwd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_dir,
  output logic                   out_neg [3],
  output logic [FRAC_BITS+37:0]  out_num [3],
  output logic [DW-1:0]          out_den
);

  localparam int CV  = FRAC_BITS + 20;
  localparam int CLO = CV / 2;
  localparam int CHI = CV - CLO;
  localparam int NW  = FRAC_BITS + 38;
  localparam int XW  = FRAC_BITS + 37;
  localparam logic [XW-1:0] HALF_FULL = XW'(64'd1000000 << (FRAC_BITS - 1));

  logic [1:0] vld;
  logic       en0, en1;

  logic [NW-1:0]     nfa [3];
  logic [CLO+15:0]   plo [3];
  logic [CHI+15:0]   phi [3];
  logic              dira;
  logic              nega [3];

  logic [NW-1:0]     numb [3];
  logic [DW-1:0]     denb;
  logic              dirb;
  logic              negb [3];

  assign en1      = !vld[1] || out_ready;
  assign en0      = !vld[0] || en1;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en0) vld[0] <= in_valid;
      if (en1) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      for (int c = 0; c < 3; c++) begin
        nfa[c] <= (NW'(in_val[c][SMW-1:0]) << (FRAC_BITS + 1)) + NW'(den_fwd >> 1);
        plo[c] <= (CLO+16)'(in_val[c][CLO-1:0]) * (CLO+16)'(max_value);
        phi[c] <= (CHI+16)'(in_val[c][CV-1:CLO]) * (CHI+16)'(max_value);
      end
      dira <= in_dir;
      nega <= in_neg;
    end
    if (en1) begin
      for (int c = 0; c < 3; c++) begin
        if (dira) begin
          numb[c] <= NW'(((XW'(phi[c]) << CLO) + XW'(plo[c]) + HALF_FULL) >> FRAC_BITS);
        end else begin
          numb[c] <= nfa[c];
        end
      end
      denb <= dira ? DW'(MILLION) : den_fwd;
      dirb <= dira;
      negb <= nega;
    end
  end

  assign out_valid = vld[1];
  assign out_dir   = dirb;
  assign out_neg   = negb;
  assign out_num   = numb;
  assign out_den   = denb;

endmodule

// File: src/ryc_div.sv
// ----------------------------------------------------------------------------
// ryc_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// An overflow check at entry saturates; a final stage limits, restores the
// sign and packs the result fields.
// ----------------------------------------------------------------------------
module ryc_div
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_dir,
  input  logic                        in_neg [3],
  input  logic [FRAC_BITS+37:0]       in_num [3],
  input  logic [DW-1:0]               in_den,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [FRAC_BITS:0]          luma_out,
  output logic signed [FRAC_BITS:0]   blue_diff_out,
  output logic signed [FRAC_BITS:0]   red_diff_out,
  output logic [15:0]                 red_out,
  output logic [15:0]                 green_out,
  output logic [15:0]                 blue_out
);

  localparam int NW    = FRAC_BITS + 38;
  localparam int QB    = (FRAC_BITS + 1 > 17) ? FRAC_BITS + 1 : 17;
  localparam int NS    = QB + 2;
  localparam int OUT_W = FRAC_BITS + 1;
  localparam logic [QB-1:0] LIM_Y   = QB'(1) << FRAC_BITS;
  localparam logic [QB-1:0] LIM_C   = QB'(1) << (FRAC_BITS - 1);
  localparam logic [QB-1:0] LIM_RGB = QB'(16'hFFFF);
  localparam logic signed [OUT_W-1:0] HALF = OUT_W'(1) << (FRAC_BITS - 1);

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [DW-1:0] rem   [QB+1][3];
  logic [QB-1:0] qn    [QB+1][3];
  logic          ovf   [QB+1][3];
  logic          neg_s [QB+1][3];
  logic          dir_s [QB+1];
  logic [DW-1:0] d_s   [QB+1];

  logic          ovf_in [3];
  logic [DW:0]   trial  [QB][3];
  logic          ge     [QB][3];

  logic [QB-1:0] lim [3];
  logic [QB-1:0] mag [3];
  logic [QB-1:0] sgn [3];

  // a stage may load when it or any stage after it is empty
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = out_ready || !(&(vld | NS'((64'd1 << k) - 64'd1)));
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ovf_in[l] = (in_num[l] >> QB) >= NW'(in_den);
    end
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < 3; l++) begin
        trial[k][l] = {rem[k][l], qn[k][l][QB-1]};
        ge[k][l]    = trial[k][l] >= {1'b0, d_s[k]};
      end
    end
  end

  // entry: quotient too wide to fit means saturation
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < 3; l++) begin
        ovf[0][l]   <= ovf_in[l];
        rem[0][l]   <= ovf_in[l] ? '0 : DW'(in_num[l] >> QB);
        qn[0][l]    <= in_num[l][QB-1:0];
        neg_s[0][l] <= in_neg[l];
      end
      dir_s[0] <= in_dir;
      d_s[0]   <= in_den;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int l = 0; l < 3; l++) begin
          rem[k][l]   <= ge[k-1][l] ? DW'(trial[k-1][l] - {1'b0, d_s[k-1]})
                                    : DW'(trial[k-1][l]);
          qn[k][l]    <= {qn[k-1][l][QB-2:0], ge[k-1][l]};
          ovf[k][l]   <= ovf[k-1][l];
          neg_s[k][l] <= neg_s[k-1][l];
        end
        dir_s[k] <= dir_s[k-1];
        d_s[k]   <= d_s[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dir_s[QB]) begin
        lim[l] = LIM_RGB;
      end else if (l == 0) begin
        lim[l] = LIM_Y;
      end else begin
        lim[l] = LIM_C;
      end
      mag[l] = (ovf[QB][l] || qn[QB][l] > lim[l]) ? lim[l] : qn[QB][l];
      sgn[l] = neg_s[QB][l] ? QB'(-mag[l]) : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      if (dir_s[QB]) begin
        luma_out      <= '0;
        blue_diff_out <= '0;
        red_diff_out  <= '0;
        red_out       <= 16'(mag[0]);
        green_out     <= 16'(mag[1]);
        blue_out      <= 16'(mag[2]);
      end else begin
        luma_out      <= OUT_W'(mag[0]);
        blue_diff_out <= OUT_W'(sgn[1]);
        red_diff_out  <= OUT_W'(sgn[2]);
        red_out       <= '0;
        green_out     <= '0;
        blue_out      <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    vld[QB] |-> (rem[QB][0] < d_s[QB]) && (rem[QB][1] < d_s[QB]) && (rem[QB][2] < d_s[QB]))
    else $error("divider remainder not below divisor");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (luma_out == '0 && blue_diff_out == '0 && red_diff_out == '0) ||
                  (red_out == '0 && green_out == '0 && blue_out == '0))
    else $error("result fields of both directions set");

  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (luma_out <= OUT_W'(LIM_Y)) &&
                  (blue_diff_out <= HALF) && (blue_diff_out >= -HALF) &&
                  (red_diff_out <= HALF) && (red_diff_out >= -HALF))
    else $error("forward result outside its saturation range");
`endif

endmodule

// File: src/rgb_ypbpr_color_converter.sv
// ----------------------------------------------------------------------------
// rgb_ypbpr_color_converter
// RGB <-> BT.601 YPbPr pixel converter, direction set by a register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transfer; m_axis returns one result per
//   pixel, in order. The cfg channel writes the direction register (index 0)
//   and max_value (index 1); cfg_ready is always high. Write config only
//   while no pixel is in flight.
// Throughput: one pixel per cycle, sustained while m_axis_tready stays high.
// Pipeline: QB + 7 register stages, where QB = max(FRAC_BITS + 1, 17) is the
//   quotient width of the restoring divider (one bit per stage). Three stages
//   weight, two build the numerator, QB + 2 divide, limit and pack.
// Reset: pipeline emptied, direction = RGB to YPbPr, max_value = 255.
// Stall: while m_axis_tready is low the held result stays put and earlier
//   stages keep filling empty slots; s_axis_tready drops only once every
//   stage holds a pixel.
// ----------------------------------------------------------------------------
module rgb_ypbpr_color_converter
  import ryc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // red_in[15:0], green_in[15:0], blue_in[15:0], luma_in, blue_diff_in,
  // red_diff_in (FRAC_BITS+2 each, signed), zero pad to bytes
  input  logic [((48 + 3*(FRAC_BITS+2) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // luma_out (FRAC_BITS+1), blue_diff_out, red_diff_out (FRAC_BITS+1,
  // signed), red_out[15:0], green_out[15:0], blue_out[15:0], zero pad
  output logic [((48 + 3*(FRAC_BITS+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW     = FRAC_BITS + 2;
  localparam int OUT_W  = FRAC_BITS + 1;
  localparam int OUT_DW = ((48 + 3*(FRAC_BITS+1) + 7) / 8) * 8;
  localparam int VW     = (FRAC_BITS + 20 > SMW) ? FRAC_BITS + 20 : SMW;
  localparam int NW     = FRAC_BITS + 38;

  logic          dir_q;
  logic [15:0]   mv_q;
  logic [DW-1:0] den_q;
  logic [15:0]   mv_eff;

  logic          w_valid, w_ready, w_dir;
  logic          w_neg [3];
  logic [VW-1:0] w_val [3];

  logic          s_valid, s_ready, s_dir;
  logic          s_neg [3];
  logic [NW-1:0] s_num [3];
  logic [DW-1:0] s_den;

  logic [OUT_W-1:0]        luma_out;
  logic signed [OUT_W-1:0] blue_diff_out, red_diff_out;
  logic [15:0]             red_out, green_out, blue_out;

  assign cfg_ready = 1'b1;
  assign mv_eff    = (cfg_data == '0) ? 16'd1 : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_q <= 1'b0;
      mv_q  <= MAX_VALUE_RST;
      den_q <= DEN_FWD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIRECTION: dir_q <= cfg_data[0];
        CFG_MAX_VALUE: begin
          mv_q  <= mv_eff;
          den_q <= DW'(mv_eff) * DW'(2 * MILLION);
        end
        default: ;
      endcase
    end
  end

  ryc_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_dir    (dir_q),
    .red       (s_axis_tdata[15:0]),
    .green     (s_axis_tdata[31:16]),
    .blue      (s_axis_tdata[47:32]),
    .luma      ($signed(s_axis_tdata[48 +: IW])),
    .blue_diff ($signed(s_axis_tdata[48 + IW +: IW])),
    .red_diff  ($signed(s_axis_tdata[48 + 2*IW +: IW])),
    .out_valid (w_valid),
    .out_ready (w_ready),
    .out_dir   (w_dir),
    .out_neg   (w_neg),
    .out_val   (w_val)
  );

  ryc_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .in_ready  (w_ready),
    .in_dir    (w_dir),
    .in_neg    (w_neg),
    .in_val    (w_val),
    .max_value (mv_q),
    .den_fwd   (den_q),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_dir   (s_dir),
    .out_neg   (s_neg),
    .out_num   (s_num),
    .out_den   (s_den)
  );

  ryc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_valid),
    .in_ready      (s_ready),
    .in_dir        (s_dir),
    .in_neg        (s_neg),
    .in_num        (s_num),
    .in_den        (s_den),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .luma_out      (luma_out),
    .blue_diff_out (blue_diff_out),
    .red_diff_out  (red_diff_out),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out)
  );

  assign m_axis_tdata = OUT_DW'({blue_out, green_out, red_out,
                                 red_diff_out, blue_diff_out, luma_out});

endmodule

// File: test/rgb_ypbpr_color_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_ypbpr_color_converter_tb
// Streams pixels through the converter in both directions and over a range
// of full-scale values, with random gaps on both the input and the output
// side. A scoreboard works out each expected pixel in exact integer
// arithmetic and compares the results field by field, in order.
// ----------------------------------------------------------------------------
module rgb_ypbpr_color_converter_tb
  import ryc_pkg::*;
();

  localparam int FB       = 16;
  localparam int IN_BITS  = ((48 + 3*(FB+2) + 7) / 8) * 8;
  localparam int OUT_BITS = ((48 + 3*(FB+1) + 7) / 8) * 8;
  localparam int PIX_BITS = 48 + 3*(FB+2);
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE = 32;

  localparam logic       DIR_FWD = 1'b0;
  localparam logic       DIR_INV = 1'b1;

  // first member sits in the top bits, so red ends up at bit 0
  typedef struct packed {
    logic [FB+1:0] red_diff;
    logic [FB+1:0] blue_diff;
    logic [FB+1:0] luma;
    logic [15:0]   blue;
    logic [15:0]   green;
    logic [15:0]   red;
  } pixel_t;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
    logic [FB:0] red_diff;
    logic [FB:0] blue_diff;
    logic [FB:0] luma;
  } result_t;

  class color_scoreboard;
    logic        dir;
    logic [15:0] full_scale;
    result_t     expected_q[$];
    int          errors;

    function new();
      dir        = DIR_FWD;
      full_scale = MAX_VALUE_RST;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_DIRECTION)
        dir = val[0];
      else if (idx == CFG_MAX_VALUE)
        full_scale = val;
    endfunction

    // nearest, ties away from zero; den > 0
    function longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
    endfunction

    function longint limit(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_pixel(pixel_t p);
      result_t e;
      longint  m, r, g, b, y, pb, pr, den, full;
      longint  ch [3];
      m = (full_scale == 16'd0) ? 1 : longint'(full_scale);
      e = '0;
      if (dir == DIR_FWD) begin
        r   = longint'(p.red);
        g   = longint'(p.green);
        b   = longint'(p.blue);
        den = 64'd1000000 * m;
        y   = 299000 * r + 587000 * g + 114000 * b;
        pb  = -168736 * r - 331264 * g + 500000 * b;
        pr  = 500000 * r - 418688 * g - 81312 * b;
        y   = limit(round_div(y * (64'sd1 <<< FB), den), 0, 64'sd1 <<< FB);
        pb  = limit(round_div(pb * (64'sd1 <<< FB), den),
                    -(64'sd1 <<< (FB-1)), 64'sd1 <<< (FB-1));
        pr  = limit(round_div(pr * (64'sd1 <<< FB), den),
                    -(64'sd1 <<< (FB-1)), 64'sd1 <<< (FB-1));
        e.luma      = y[FB:0];
        e.blue_diff = pb[FB:0];
        e.red_diff  = pr[FB:0];
      end else begin
        y    = $signed(p.luma);
        pb   = $signed(p.blue_diff);
        pr   = $signed(p.red_diff);
        full = 64'd1000000 * (64'sd1 <<< FB);
        ch[0] = 1000000 * y + 1402000 * pr;
        ch[1] = 1000000 * y - 344136 * pb - 714136 * pr;
        ch[2] = 1000000 * y + 1772000 * pb;
        for (int i = 0; i < 3; i++)
          ch[i] = round_div(limit(ch[i], 0, full) * m, full);
        e.red   = ch[0][15:0];
        e.green = ch[1][15:0];
        e.blue  = ch[2][15:0];
      end
      expected_q.push_back(e);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string what, longint want, longint seen);
      $display("%0t: %s wrong, expected %0d got %0d", $realtime, what, want, seen);
      errors++;
    endtask

    task check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result transfer, count", 0, 1);
      end else begin
        e = expected_q.pop_front();
        if (got.luma !== e.luma) report("luma_out", e.luma, got.luma);
        if (got.blue_diff !== e.blue_diff)
          report("blue_diff_out", $signed(e.blue_diff), $signed(got.blue_diff));
        if (got.red_diff !== e.red_diff)
          report("red_diff_out", $signed(e.red_diff), $signed(got.red_diff));
        if (got.red !== e.red) report("red_out", e.red, got.red);
        if (got.green !== e.green) report("green_out", e.green, got.green);
        if (got.blue !== e.blue) report("blue_out", e.blue, got.blue);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic [IN_BITS-1:0]  s_axis_tdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [OUT_BITS-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_data;

  color_scoreboard sb;
  logic            tx_steady;
  logic            rx_steady;
  logic            cur_dir;
  logic [15:0]     cur_scale;

  rgb_ypbpr_color_converter #(.FRAC_BITS(FB)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("rgb_ypbpr_color_converter: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[$bits(result_t)-1:0]);
  end

  // output side: random hold-off before each result transfer
  initial begin : rx_side
    int gap;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  function automatic pixel_t mk(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                logic [FB+1:0] y, logic [FB+1:0] pb,
                                logic [FB+1:0] pr);
    pixel_t p;
    p = '{red_diff: pr, blue_diff: pb, luma: y, blue: b, green: g, red: r};
    return p;
  endfunction

  function automatic logic [FB+1:0] rand_wide();
    return (FB+2)'($urandom);
  endfunction

  function automatic logic [FB+1:0] rand_frac(int lo, int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    return v[FB+1:0];
  endfunction

  function automatic pixel_t random_pixel(logic dir, logic [15:0] scale);
    pixel_t p;
    int     kind;
    int     top;
    p = PIX_BITS'({$urandom, $urandom, $urandom, $urandom});
    kind = $urandom_range(0, 9);
    top = int'(scale);
    if (dir == DIR_FWD) begin
      if (kind < 7) begin
        p.red   = 16'($urandom_range(0, top));
        p.green = 16'($urandom_range(0, top));
        p.blue  = 16'($urandom_range(0, top));
      end else if (kind == 7) begin
        p.red   = $urandom_range(0, 1) ? scale : 16'd0;
        p.green = $urandom_range(0, 1) ? scale : 16'd0;
        p.blue  = $urandom_range(0, 1) ? scale : 16'd0;
      end
      // other kinds keep full 16-bit samples, usually above full scale
    end else begin
      if (kind < 7) begin
        p.luma      = rand_frac(0, 1 << FB);
        p.blue_diff = rand_frac(-(1 << (FB-1)), 1 << (FB-1));
        p.red_diff  = rand_frac(-(1 << (FB-1)), 1 << (FB-1));
      end else if (kind == 7) begin
        p.luma      = $urandom_range(0, 1) ? rand_frac(1 << FB, 1 << FB) : '0;
        p.blue_diff = $urandom_range(0, 1) ? rand_frac(1 << (FB-1), 1 << (FB-1))
                                           : rand_frac(-(1 << (FB-1)), -(1 << (FB-1)));
        p.red_diff  = $urandom_range(0, 1) ? rand_frac(1 << (FB-1), 1 << (FB-1))
                                           : rand_frac(-(1 << (FB-1)), -(1 << (FB-1)));
      end else begin
        p.luma      = rand_wide();
        p.blue_diff = rand_wide();
        p.red_diff  = rand_wide();
      end
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = IN_BITS'(p);
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  // hold the input until every outstanding pixel has come back
  task automatic wait_empty();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 16'($urandom);
  endtask

  task automatic run_phase(input logic dir, input logic [15:0] scale, input int n,
                           input logic steady);
    wait_empty();
    // upper data bits of the direction write are don't-care
    write_reg(CFG_DIRECTION, (16'($urandom) & 16'hFFFE) | 16'(dir));
    write_reg(CFG_MAX_VALUE, scale);
    tx_steady = steady;
    rx_steady = steady;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2)
        wait_empty();
      if (!steady && $urandom_range(0, 5) == 0) begin
        tx_steady = ~tx_steady;
        rx_steady = 1'($urandom_range(0, 1));
      end
      send_pixel(random_pixel(dir, scale));
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_DIRECTION;
    cfg_data      = '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset settings: forward, full scale 255
    send_pixel(mk(16'd0, 16'd0, 16'd0, '1, '1, '1));
    send_pixel(mk(16'd255, 16'd255, 16'd255, '0, '0, '0));
    send_pixel(mk(16'd255, 16'd0, 16'd0, '0, '0, '0));
    send_pixel(mk(16'd0, 16'd255, 16'd0, '0, '0, '0));
    send_pixel(mk(16'd0, 16'd0, 16'd255, '0, '0, '0));
    send_pixel(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0, '0));
    send_pixel(mk(16'hFFFF, 16'd0, 16'd0, '0, '0, '0));
    send_pixel(mk(16'd0, 16'hFFFF, 16'd0, '0, '0, '0));
    send_pixel(mk(16'd0, 16'd0, 16'hFFFF, '0, '0, '0));
    send_pixel(mk(16'd128, 16'd64, 16'd200, '0, '0, '0));

    wait_empty();
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_DIRECTION, 16'(DIR_INV));
    // mid grey at 255 lands exactly on a half
    send_pixel(mk('0, '0, '0, rand_frac(1 << (FB-1), 1 << (FB-1)), '0, '0));
    send_pixel(mk('1, '1, '1, '0, '0, '0));
    send_pixel(mk('0, '0, '0, rand_frac(1 << FB, 1 << FB), '0, '0));
    send_pixel(mk('0, '0, '0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    send_pixel(mk('0, '0, '0, 18'h20000, 18'h20000, 18'h20000));
    send_pixel(mk('0, '0, '0, 18'h1FFFF, 18'h20000, 18'h1FFFF));
    send_pixel(mk('0, '0, '0, 18'h20000, 18'h1FFFF, 18'h20000));
    send_pixel(mk('0, '0, '0, rand_frac(1 << (FB-1), 1 << (FB-1)),
                  rand_frac(1 << (FB-1), 1 << (FB-1)),
                  rand_frac(-(1 << (FB-1)), -(1 << (FB-1)))));
    send_pixel(mk('0, '0, '0, '0, rand_frac(-(1 << (FB-1)), -(1 << (FB-1))),
                  rand_frac(1 << (FB-1), 1 << (FB-1))));

    run_phase(DIR_FWD, 16'd1, 70, 1'b0);
    run_phase(DIR_FWD, 16'hFFFF, 80, 1'b0);
    run_phase(DIR_INV, 16'hFFFF, 80, 1'b0);
    run_phase(DIR_INV, 16'd1, 70, 1'b0);
    cur_scale = 16'($urandom_range(2, 65534));
    run_phase(DIR_FWD, cur_scale, 80, 1'b0);
    cur_scale = 16'($urandom_range(2, 65534));
    run_phase(DIR_INV, cur_scale, 80, 1'b0);
    // zero full scale behaves as one
    run_phase(DIR_FWD, 16'd0, 40, 1'b0);
    run_phase(DIR_INV, 16'd0, 40, 1'b0);
    run_phase(DIR_FWD, 16'd1023, 80, 1'b1);
    cur_dir = 1'($urandom_range(0, 1));
    run_phase(cur_dir, 16'd255, 80, 1'b1);

    wait_empty();
    if (sb.errors == 0)
      $display("rgb_ypbpr_color_converter: match");
    else
      $display("rgb_ypbpr_color_converter: mismatch");
    $finish;
  end

endmodule

// File: files.f
src/ryc_pkg.sv
src/ryc_weight.sv
src/ryc_scale.sv
src/ryc_div.sv
src/rgb_ypbpr_color_converter.sv
test/rgb_ypbpr_color_converter_tb.sv
